### rtl/core/srng_pkg.sv
`timescale 1ns / 1ps

package srng_pkg;

   localparam int VAL_W      = 31;
   localparam int IDX_W      = 6;
   localparam int TABLE_SIZE = 56;

   localparam logic [VAL_W-1:0] MODULUS     = 31'h7FFF_FFFF;
   localparam logic [31:0]      START_VALUE = 32'd161803398;
   localparam logic [31:0]      WIDE_CENTER = 32'd2147483646;

   localparam logic [IDX_W-1:0] LAGS        = 6'd55;
   localparam logic [IDX_W-1:0] SPREAD_STEP = 6'd21;
   localparam logic [IDX_W-1:0] TRAIL_START = 6'd21;
   localparam logic [IDX_W-1:0] IDX_ONE     = 6'd1;
   // partner of entry i in a mixing pass: 1 + (i + 30) mod 55
   localparam logic [IDX_W-1:0] MIX_SPLIT   = 6'd25;
   localparam logic [IDX_W-1:0] MIX_UP      = 6'd31;
   localparam logic [IDX_W-1:0] MIX_DOWN    = 6'd24;

   localparam logic [1:0] LAST_PASS = 2'd3;
   localparam logic [6:0] MAX_BYTES = 7'd64;

   typedef enum logic [1:0] {
      OP_INIT  = 2'd0,
      OP_RAW   = 2'd1,
      OP_RANGE = 2'd2,
      OP_BYTES = 2'd3
   } op_type;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'h0001,
      ST_SEED    = 15'h0002,
      ST_START   = 15'h0004,
      ST_SPREAD  = 15'h0008,
      ST_MIX_RD  = 15'h0010,
      ST_MIX_WR  = 15'h0020,
      ST_CHECK   = 15'h0040,
      ST_DRAW_RD = 15'h0080,
      ST_DRAW_WR = 15'h0100,
      ST_PREP    = 15'h0200,
      ST_MUL     = 15'h0400,
      ST_TRIPLE  = 15'h0800,
      ST_SUM     = 15'h1000,
      ST_ADD     = 15'h2000,
      ST_EMIT    = 15'h4000
   } state_type;

   // (a - b) mod 2^31-1
   function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
      logic [VAL_W-1:0] r;
      if (a >= b) begin
         r = a - b;
      end else begin
         r = a + (MODULUS - b);
      end
      return r;
   endfunction

endpackage

### rtl/core/srng_ram.sv
`timescale 1ns / 1ps

module srng_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 56
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/core/subtractive_lagged_rng.sv
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tuser op; tdata min, max, byte_count
// rsp     | out | rsp_tvalid/tready    | tdata value; tuser range_error; tlast
// csr     | in  | csr_wr_en            | csr_wr_data seed
//
// Raw sample: two-port table read, modular subtract and write-back.
// Ranged value: one sample, or two for a span of 2^31 or more (one 32x32 multiply,
// then a shift-and-add fraction). Bytes: one sample drawn per byte.
// Initialize: 54 spread writes, then 4 x 55 read/write mixing steps.
// req_tready is high only in idle; a held result stalls the next emit, not the draw.
// reset clears the control state and indices; the table is valid only after op 0.
`timescale 1ns / 1ps

module subtractive_lagged_rng
   import srng_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // min_value[31:0], max_value[63:32], byte_count[70:64]
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value
   output logic        rsp_tuser,   // range_error
   output logic        rsp_tlast
);

   state_type state_ff, state_in;

   logic [31:0]       seed_ff, seed_in;
   logic [IDX_W-1:0]  lead_ff, lead_in;
   logic [IDX_W-1:0]  trail_ff, trail_in;
   logic              rsp_valid_ff, rsp_valid_in;

   op_type            op_ff, op_in;
   logic signed [31:0] lo_ff, lo_in;
   logic signed [31:0] hi_ff, hi_in;
   logic [6:0]        rem_ff, rem_in;
   logic [31:0]       span_ff, span_in;
   logic              large_ff, large_in;
   logic              drew_ff, drew_in;
   logic [VAL_W-1:0]  samp_ff, samp_in;
   logic [VAL_W-1:0]  a_ff, a_in;
   logic [31:0]       opnd_ff, opnd_in;
   logic [63:0]       prod_ff, prod_in;
   logic [65:0]       tri_ff, tri_in;
   logic [31:0]       q_ff, q_in;
   logic [VAL_W-1:0]  cur_ff, cur_in;
   logic [VAL_W-1:0]  prev_ff, prev_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [1:0]        pass_ff, pass_in;
   logic [31:0]       res_value_ff, res_value_in;
   logic              res_err_ff, res_err_in;
   logic              res_last_ff, res_last_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_err_ff, rsp_err_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [VAL_W-1:0]  ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr_a;
   logic [IDX_W-1:0]  ram_rd_addr_b;
   logic [VAL_W-1:0]  ram_rd_data_a;
   logic [VAL_W-1:0]  ram_rd_data_b;

   logic [IDX_W-1:0]  draw_lead;
   logic [IDX_W-1:0]  draw_trail;
   logic [IDX_W-1:0]  mix_partner;
   logic [VAL_W-1:0]  diff;
   logic [VAL_W-1:0]  sample;
   logic [6:0]        k_sum;
   logic [32:0]       start_diff;
   logic [32:0]       start_abs;
   logic [32:0]       span_diff;
   logic [97:0]       frac_sum;
   logic [6:0]        req_count;
   logic              out_free;
   logic              req_fire;

   srng_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign draw_lead   = (lead_ff == LAGS) ? IDX_ONE : lead_ff + IDX_ONE;
   assign draw_trail  = (trail_ff == LAGS) ? IDX_ONE : trail_ff + IDX_ONE;
   assign mix_partner = (idx_ff < MIX_SPLIT) ? idx_ff + MIX_UP : idx_ff - MIX_DOWN;

   // shared modular subtractor: spread, mixing and draws
   always_comb begin
      if (state_ff == ST_SPREAD) begin
         diff = mod_sub(cur_ff, prev_ff);
      end else begin
         diff = mod_sub(ram_rd_data_a, ram_rd_data_b);
      end
   end

   assign sample     = (diff == MODULUS) ? MODULUS - VAL_W'(1) : diff;
   assign k_sum      = {1'b0, k_ff} + {1'b0, SPREAD_STEP};
   assign start_diff = {1'b0, START_VALUE} - {2'b00, cur_ff};
   assign start_abs  = start_diff[32] ? (33'd0 - start_diff) : start_diff;
   assign span_diff  = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff};
   assign frac_sum   = (large_ff ? ({34'd0, prod_ff} << 32) : ({34'd0, prod_ff} << 33))
                       + {32'd0, tri_ff};
   assign req_count  = (req_tdata[70:64] > MAX_BYTES) ? MAX_BYTES : req_tdata[70:64];

   always_comb begin
      ram_rd_addr_a = draw_lead;
      ram_rd_addr_b = draw_trail;
      if (state_ff == ST_MIX_RD) begin
         ram_rd_addr_a = idx_ff;
         ram_rd_addr_b = mix_partner;
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = draw_lead;
      ram_wr_data = sample;
      case (state_ff)
         ST_START: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = LAGS;
            ram_wr_data = start_abs[VAL_W-1:0];
         end
         ST_SPREAD: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = k_ff;
            ram_wr_data = prev_ff;
         end
         ST_MIX_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = diff;
         end
         ST_DRAW_WR: begin
            ram_wr_en   = 1'b1;
         end
         default: begin
            ram_wr_en   = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      lead_in      = lead_ff;
      trail_in     = trail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      op_in        = op_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rem_in       = rem_ff;
      span_in      = span_ff;
      large_in     = large_ff;
      drew_in      = drew_ff;
      samp_in      = samp_ff;
      a_in         = a_ff;
      opnd_in      = opnd_ff;
      prod_in      = prod_ff;
      tri_in       = tri_ff;
      q_in         = q_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      res_value_in = res_value_ff;
      res_err_in   = res_err_ff;
      res_last_in  = res_last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = op_type'(req_tuser);
               lo_in   = req_tdata[31:0];
               hi_in   = req_tdata[63:32];
               rem_in  = req_count;
               drew_in = 1'b0;
               case (op_type'(req_tuser))
                  OP_INIT:  state_in = ST_SEED;
                  OP_RAW:   state_in = ST_DRAW_RD;
                  OP_RANGE: state_in = ST_CHECK;
                  OP_BYTES: state_in = (req_count == 7'd0) ? ST_IDLE : ST_DRAW_RD;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEED: begin
            if (seed_ff == 32'h8000_0000) begin
               cur_in = MODULUS;
            end else if (seed_ff[31]) begin
               cur_in = VAL_W'(32'd0 - seed_ff);
            end else begin
               cur_in = seed_ff[VAL_W-1:0];
            end
            state_in = ST_START;
         end
         ST_START: begin
            cur_in   = start_abs[VAL_W-1:0];
            prev_in  = VAL_W'(1);
            k_in     = SPREAD_STEP;
            idx_in   = IDX_ONE;
            state_in = ST_SPREAD;
         end
         ST_SPREAD: begin
            prev_in = diff;
            cur_in  = prev_ff;
            k_in    = (k_sum >= {1'b0, LAGS}) ? IDX_W'(k_sum - {1'b0, LAGS}) : k_sum[IDX_W-1:0];
            if (idx_ff == LAGS - IDX_ONE) begin
               idx_in   = IDX_ONE;
               pass_in  = 2'd0;
               state_in = ST_MIX_RD;
            end else begin
               idx_in = idx_ff + IDX_ONE;
            end
         end
         ST_MIX_RD: begin
            state_in = ST_MIX_WR;
         end
         ST_MIX_WR: begin
            state_in = ST_MIX_RD;
            if (idx_ff == LAGS) begin
               idx_in = IDX_ONE;
               if (pass_ff == LAST_PASS) begin
                  lead_in      = '0;
                  trail_in     = TRAIL_START;
                  res_value_in = '0;
                  res_err_in   = 1'b0;
                  res_last_in  = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  pass_in = pass_ff + 2'd1;
               end
            end else begin
               idx_in = idx_ff + IDX_ONE;
            end
         end
         ST_CHECK: begin
            if (lo_ff > hi_ff) begin
               res_value_in = '0;
               res_err_in   = 1'b1;
               res_last_in  = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               span_in  = span_diff[31:0];
               large_in = span_diff[31];
               state_in = ST_DRAW_RD;
            end
         end
         ST_DRAW_RD: begin
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            lead_in     = draw_lead;
            trail_in    = draw_trail;
            samp_in     = sample;
            a_in        = samp_ff;
            res_err_in  = 1'b0;
            case (op_ff)
               OP_RAW: begin
                  res_value_in = {1'b0, sample};
                  res_last_in  = 1'b1;
                  state_in     = ST_EMIT;
               end
               OP_BYTES: begin
                  res_value_in = {24'd0, sample[7:0]};
                  res_last_in  = (rem_ff == 7'd1);
                  rem_in       = rem_ff - 7'd1;
                  state_in     = ST_EMIT;
               end
               default: begin
                  if (large_ff && !drew_ff) begin
                     drew_in  = 1'b1;
                     state_in = ST_DRAW_RD;
                  end else begin
                     state_in = ST_PREP;
                  end
               end
            endcase
         end
         ST_PREP: begin
            if (!large_ff) begin
               opnd_in = {1'b0, samp_ff};
            end else if (samp_ff[0]) begin
               opnd_in = WIDE_CENTER + {1'b0, a_ff};
            end else begin
               opnd_in = WIDE_CENTER - {1'b0, a_ff};
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = 64'(opnd_ff) * 64'(span_ff);
            state_in = ST_TRIPLE;
         end
         ST_TRIPLE: begin
            tri_in   = {2'b00, prod_ff} + {1'b0, prod_ff, 1'b0};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            q_in     = frac_sum[95:64];
            state_in = ST_ADD;
         end
         ST_ADD: begin
            res_value_in = q_ff + $unsigned(lo_ff);
            res_err_in   = 1'b0;
            res_last_in  = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_value_ff;
               rsp_err_in   = res_err_ff;
               rsp_last_in  = res_last_ff;
               state_in     = res_last_ff ? ST_IDLE : ST_DRAW_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         lead_ff      <= '0;
         trail_ff     <= TRAIL_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         lead_ff      <= lead_in;
         trail_ff     <= trail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rem_ff       <= rem_in;
      span_ff      <= span_in;
      large_ff     <= large_in;
      drew_ff      <= drew_in;
      samp_ff      <= samp_in;
      a_ff         <= a_in;
      opnd_ff      <= opnd_in;
      prod_ff      <= prod_in;
      tri_ff       <= tri_in;
      q_ff         <= q_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      pass_ff      <= pass_in;
      res_value_ff <= res_value_in;
      res_err_ff   <= res_err_in;
      res_last_ff  <= res_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_wr_addr_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (ram_wr_addr != '0) && (ram_wr_addr <= LAGS))
      else $error("table write outside entries 1..55");

   a_draw_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW_RD) |-> (ram_rd_addr_a != '0) && (ram_rd_addr_b != '0))
      else $error("draw reads unused entry 0");

   a_lag_distance: assert property (@(posedge clock) disable iff (reset)
      (({1'b0, lead_ff} + {1'b0, TRAIL_START}) == {1'b0, trail_ff}) ||
      (({1'b0, lead_ff} + {1'b0, TRAIL_START}) == ({1'b0, trail_ff} + {1'b0, LAGS})))
      else $error("lead and trail indices lost their lag");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> rsp_last_ff && (rsp_data_ff == '0))
      else $error("range error result not a single zero transaction");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import srng_pkg::*;

   localparam int          HOLD_CYCLES   = 400;
   localparam int          SETTLE_CYCLES = 40;
   localparam int unsigned CYCLE_LIMIT   = 4_000_000;
   localparam int          PHASE_ITEMS   = 47;
   localparam bit [63:0]   UNIT_FRAC     = 64'h0000_0002_0000_0003;
   localparam bit [63:0]   WIDE_FRAC     = 64'h0000_0001_0000_0003;
   localparam logic [31:0] MOST_NEG      = 32'h8000_0000;
   localparam logic [31:0] MOST_POS      = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [31:0] value;
      logic        range_error;
      logic        last;
   } sample_type;

   class sample_tracker;
      bit [VAL_W-1:0] lags [TABLE_SIZE];
      bit [IDX_W-1:0] lead_pos;
      bit [IDX_W-1:0] trail_pos;
      bit [31:0]      seed;
      sample_type     pending_q [$];
      int             mismatches;
      int             compared;

      function new();
         foreach (lags[i]) lags[i] = '0;
         lead_pos   = '0;
         trail_pos  = TRAIL_START;
         seed       = '0;
         mismatches = 0;
         compared   = 0;
      endfunction

      function bit [VAL_W-1:0] diff_mod(bit [VAL_W-1:0] a, bit [VAL_W-1:0] b);
         if (a >= b) return a - b;
         return a + (MODULUS - b);
      endfunction

      function bit [63:0] mul_top(bit [63:0] x, bit [63:0] y);
         bit [127:0] p;
         p = {64'd0, x} * {64'd0, y};
         return p[127:64];
      endfunction

      function void fill_lags();
         longint         s;
         longint         mag;
         longint         start;
         bit [VAL_W-1:0] cur;
         bit [VAL_W-1:0] prev;
         bit [IDX_W-1:0] k;
         bit [IDX_W-1:0] partner;
         s = longint'($signed(seed));
         if (seed == MOST_NEG) mag = longint'(MODULUS);
         else if (s < 0) mag = -s;
         else mag = s;
         start = longint'(START_VALUE) - mag;
         if (start < 0) start = -start;
         cur = start[VAL_W-1:0];
         lags[LAGS] = cur;
         prev = VAL_W'(1);
         for (int i = 1; i < int'(LAGS); i++) begin
            k = IDX_W'((int'(SPREAD_STEP) * i) % int'(LAGS));
            lags[k] = prev;
            prev = diff_mod(cur, prev);
            cur = lags[k];
         end
         for (int pass = 1; pass < 5; pass++) begin
            for (int i = 1; i < TABLE_SIZE; i++) begin
               partner = IDX_W'(1 + (i + 30) % int'(LAGS));
               lags[IDX_W'(i)] = diff_mod(lags[IDX_W'(i)], lags[partner]);
            end
         end
         lead_pos  = '0;
         trail_pos = TRAIL_START;
      endfunction

      function bit [VAL_W-1:0] next_sample();
         bit [IDX_W-1:0] i1;
         bit [IDX_W-1:0] i2;
         bit [VAL_W-1:0] a;
         bit [VAL_W-1:0] b;
         bit [VAL_W-1:0] n;
         i1 = lead_pos + IDX_ONE;
         i2 = trail_pos + IDX_ONE;
         if (i1 > LAGS) i1 = IDX_ONE;
         if (i2 > LAGS) i2 = IDX_ONE;
         a = lags[i1];
         b = lags[i2];
         if (a >= b) begin
            n = a - b;
            if (n == MODULUS) n = n - VAL_W'(1);
         end else begin
            n = a + (MODULUS - b);
         end
         lags[i1]  = n;
         lead_pos  = i1;
         trail_pos = i2;
         return n;
      endfunction

      function void push(logic [31:0] value, logic err, logic last);
         sample_type r;
         r.value       = value;
         r.range_error = err;
         r.last        = last;
         pending_q.push_back(r);
      endfunction

      function void predict_range(logic [31:0] lo_in, logic [31:0] hi_in);
         longint    lo;
         longint    hi;
         bit [63:0] span;
         bit [63:0] a;
         bit [63:0] b;
         bit [63:0] t;
         bit [63:0] q;
         lo = longint'($signed(lo_in));
         hi = longint'($signed(hi_in));
         if (lo > hi) begin
            push('0, 1'b1, 1'b1);
            return;
         end
         span = hi - lo;
         if (span <= 64'(MODULUS)) begin
            a = 64'(next_sample());
            q = mul_top(a * span, UNIT_FRAC);
         end else begin
            a = 64'(next_sample());
            b = 64'(next_sample());
            t = (b[0] == 1'b0) ? 64'(WIDE_CENTER) - a : 64'(WIDE_CENTER) + a;
            q = mul_top(t * span, WIDE_FRAC);
         end
         push(q[31:0] + lo_in, 1'b0, 1'b1);
      endfunction

      function void note_request(op_type op, logic [31:0] lo, logic [31:0] hi,
                                 logic [6:0] cnt);
         int             n;
         bit [VAL_W-1:0] s;
         case (op)
            OP_INIT: begin
               fill_lags();
               push('0, 1'b0, 1'b1);
            end
            OP_RAW: begin
               push({1'b0, next_sample()}, 1'b0, 1'b1);
            end
            OP_RANGE: begin
               predict_range(lo, hi);
            end
            default: begin
               n = (cnt > MAX_BYTES) ? int'(MAX_BYTES) : int'(cnt);
               for (int i = 0; i < n; i++) begin
                  s = next_sample();
                  push({24'd0, s[7:0]}, 1'b0, i == n - 1);
               end
            end
         endcase
      endfunction

      function void check_response(logic [31:0] value, logic err, logic last);
         sample_type e;
         compared++;
         if (pending_q.size() == 0) begin
            mismatches++;
            $error("unexpected result: value %h range_error %b last %b", value, err, last);
            return;
         end
         e = pending_q.pop_front();
         if (value !== e.value) begin
            mismatches++;
            $error("value: expected %h, got %h", e.value, value);
         end
         if (err !== e.range_error) begin
            mismatches++;
            $error("range_error: expected %b, got %b", e.range_error, err);
         end
         if (last !== e.last) begin
            mismatches++;
            $error("last: expected %b, got %b", e.last, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   sample_tracker tracker;
   bit            steady;
   bit            hold_request;
   int            op_total [4];
   int            seeds_used;

   subtractive_lagged_rng dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(input op_type op, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [6:0] cnt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, cnt, hi, lo};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(op, lo, hi, cnt);
      op_total[int'(op)]++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (tracker.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] s);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.seed = s;
      seeds_used++;
   endtask

   task automatic random_request();
      int          r;
      op_type      op;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [6:0]  cnt;
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_INIT;
      else if (r < 35) op = OP_RAW;
      else if (r < 70) op = OP_RANGE;
      else op = OP_BYTES;
      case ($urandom_range(0, 9))
         0: begin
            lo = $urandom;
            hi = $urandom;
         end
         6: begin
            lo = MOST_NEG;
            hi = $urandom;
         end
         7: begin
            lo = $urandom;
            hi = MOST_POS;
         end
         8: begin
            lo = $urandom;
            hi = lo;
         end
         9: begin
            lo = $urandom;
            hi = lo - 32'd1;
         end
         default: begin
            lo = 32'($urandom_range(0, 2000)) - 32'd1000;
            hi = lo + 32'($urandom_range(0, 5000));
         end
      endcase
      r = $urandom_range(0, 19);
      if (r == 0) cnt = 7'($urandom_range(0, 127));
      else if (r == 1) cnt = '0;
      else cnt = 7'($urandom_range(1, 8));
      send_request(op, lo, hi, cnt);
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $error("timeout after %0d cycles, %0d results outstanding", cycles,
             tracker.pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [31:0] seed_list [7];
      tracker      = new();
      steady       = 1'b0;
      hold_request = 1'b0;
      seeds_used   = 0;
      foreach (op_total[i]) op_total[i] = 0;
      seed_list = '{MOST_NEG, MOST_POS, 32'hFFFF_FFFF, START_VALUE,
                    START_VALUE + 32'd1, -START_VALUE, $urandom};
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_INIT;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, every op, boundary spans and byte counts
      write_seed('0);
      send_request(OP_INIT, $urandom, $urandom, 7'($urandom));
      send_request(OP_RAW, $urandom, $urandom, 7'($urandom));
      send_request(OP_RAW, '0, '0, '0);
      send_request(OP_RANGE, '0, '0, '0);
      send_request(OP_RANGE, MOST_NEG, MOST_POS, 7'h7F);
      send_request(OP_RANGE, MOST_POS, MOST_NEG, '0);
      send_request(OP_RANGE, '0, MOST_POS, '0);
      send_request(OP_RANGE, 32'hFFFF_FFFF, MOST_POS, '0);
      send_request(OP_RANGE, MOST_NEG, 32'hFFFF_FFFF, '0);
      send_request(OP_RANGE, MOST_NEG, MOST_NEG, '0);
      send_request(OP_RANGE, MOST_POS, MOST_POS, '0);
      send_request(OP_RANGE, 32'd5, 32'd4, '0);
      send_request(OP_RANGE, -32'd1000, 32'd1000, '0);
      send_request(OP_BYTES, '0, '0, 7'd0);
      send_request(OP_BYTES, '0, '0, 7'd1);
      send_request(OP_BYTES, MOST_POS, MOST_NEG, 7'd64);
      send_request(OP_BYTES, '0, '0, 7'd65);
      send_request(OP_BYTES, '0, '0, 7'd127);
      send_request(OP_INIT, '0, '0, '0);
      send_request(OP_RAW, '0, '0, '0);
      send_request(OP_BYTES, '0, '0, 7'd2);

      foreach (seed_list[p]) begin
         drain_results();
         write_seed(seed_list[p]);
         steady = ($urandom_range(0, 3) == 0);
         send_request(OP_INIT, $urandom, $urandom, 7'($urandom));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == 5) hold_request = 1'b1;
            if (k == 24) drain_results();
            if (k % 16 == 15) steady = ($urandom_range(0, 3) == 0);
            random_request();
         end
      end

      drain_results();
      $display("Ran %0d seeds: %0d init, %0d raw, %0d ranged, %0d byte-run transactions",
               seeds_used, op_total[OP_INIT], op_total[OP_RAW], op_total[OP_RANGE],
               op_total[OP_BYTES]);
      $display("Compared %0d results, %0d field errors", tracker.compared,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
